// ----- sv/ills_pkg.sv -----
// ----------------------------------------------------------------------------
// ills_pkg
// Shared types and constants for the indexed linked list splicer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ills_pkg;

    localparam int ID_W   = 17;
    localparam int MAX_ID = 131071;
    localparam int DEPTH  = MAX_ID + 1;

    typedef logic [ID_W-1:0] t_id;

    localparam t_id MAX_ID_V = t_id'(MAX_ID);

    localparam logic [1:0] OP_INS_AFTER  = 2'd0;
    localparam logic [1:0] OP_INS_BEFORE = 2'd1;
    localparam logic [1:0] OP_QUERY      = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        t_id        target_id;
        t_id        run_length;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        t_id        left_id;
        t_id        right_id;
    } t_out;

    typedef enum logic [1:0] {
        RES_QUERY,
        RES_NONE,
        RES_REJECT
    } t_res_kind;

    typedef enum logic [1:0] {
        LINK_FIRST,
        LINK_SECOND,
        LINK_THIRD
    } t_link_step;

    typedef struct packed {
        logic       clr_step;
        logic       load;
        logic       rd_first;
        logic       rd_second;
        logic       capture;
        logic       link_en;
        t_link_step link_step;
        logic       pc_upd;
        logic       res_ld;
        t_res_kind  res_kind;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic nop;
        logic is_query;
        logic t_ok;
        logic ovf;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/ills_datapath.sv -----
// ----------------------------------------------------------------------------
// ills_datapath
// Link tables, placed count, init sweep, splice pointer muxing and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ills_datapath import ills_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire t_in  i_item,
    output t_sts      o_sts,
    output t_out      o_result
);

    t_id  r_prev_mem [0:DEPTH-1];
    t_id  r_next_mem [0:DEPTH-1];

    t_in  r_in;
    t_id  r_pc;
    t_id  r_clr_idx;
    logic r_clr_done;
    t_id  r_pa;
    t_id  r_nt;
    t_id  r_prev_q;
    t_id  r_next_q;
    t_out r_res;

    logic [ID_W:0] e_wide;
    t_id  s_id;
    t_id  e_id;
    t_id  nb_id;
    logic is_query;
    logic is_ins;
    logic is_before;
    logic skip;
    logic q_fail;
    t_id  link_a;
    t_id  link_b;
    logic clr_we;
    t_id  clr_prev;
    t_id  clr_next;
    logic we_p;
    logic we_n;
    t_id  wa_p;
    t_id  wa_n;
    t_id  wd_p;
    t_id  wd_n;
    logic re_p;
    logic re_n;
    t_id  ra_p;
    t_id  ra_n;

    assign e_wide    = {1'b0, r_pc} + {1'b0, r_in.run_length};
    assign s_id      = r_pc + t_id'(1);
    assign e_id      = e_wide[ID_W-1:0];
    assign nb_id     = (e_id == MAX_ID_V) ? '0 : e_id + t_id'(1);
    assign is_query  = (r_in.operation == OP_QUERY);
    assign is_before = (r_in.operation == OP_INS_BEFORE);
    assign is_ins    = (r_in.operation == OP_INS_AFTER) || is_before;
    assign skip      = !is_before && (r_nt == s_id);
    assign q_fail    = (r_prev_q == '0) || (r_next_q == '0) || (r_next_q > r_pc);

    assign o_sts.clr_done = r_clr_done;
    assign o_sts.is_query = is_query;
    assign o_sts.nop      = !(is_ins || is_query) || (is_ins && r_in.run_length == '0);
    assign o_sts.t_ok     = (r_in.target_id != '0) && (r_in.target_id <= r_pc)
                            && (r_in.target_id <= MAX_ID_V);
    assign o_sts.ovf      = (e_wide > (ID_W+1)'(MAX_ID));

    always_comb begin
        unique case (i_cmd.link_step)
            LINK_FIRST: begin
                link_a = is_before ? r_prev_q : e_id;
                link_b = is_before ? s_id : r_nt;
            end
            LINK_SECOND: begin
                link_a = is_before ? e_id : r_in.target_id;
                link_b = is_before ? r_in.target_id : s_id;
            end
            default: begin
                link_a = r_pa;
                link_b = nb_id;
            end
        endcase
    end

    assign clr_we   = i_cmd.clr_step && !r_clr_done;
    assign clr_prev = (r_clr_idx == '0) ? '0 : r_clr_idx - t_id'(1);
    assign clr_next = ((r_clr_idx == '0) || (r_clr_idx == MAX_ID_V)) ? '0
                      : r_clr_idx + t_id'(1);

    assign we_p = clr_we || (i_cmd.link_en && !skip && link_b != '0);
    assign we_n = clr_we || (i_cmd.link_en && !skip && link_a != '0);
    assign wa_p = clr_we ? r_clr_idx : link_b;
    assign wd_p = clr_we ? clr_prev  : link_a;
    assign wa_n = clr_we ? r_clr_idx : link_a;
    assign wd_n = clr_we ? clr_next  : link_b;

    assign re_p = i_cmd.rd_first || i_cmd.rd_second;
    assign re_n = i_cmd.rd_first;
    assign ra_p = (i_cmd.rd_first && !is_query) ? s_id : r_in.target_id;
    assign ra_n = r_in.target_id;

    always_ff @(posedge i_clk) begin
        if (we_p) begin
            r_prev_mem[wa_p] <= wd_p;
        end
        if (re_p) begin
            r_prev_q <= r_prev_mem[ra_p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_n) begin
            r_next_mem[wa_n] <= wd_n;
        end
        if (re_n) begin
            r_next_q <= r_next_mem[ra_n];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= t_id'(1);
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
        end else begin
            if (clr_we) begin
                r_clr_idx <= r_clr_idx + t_id'(1);
                if (r_clr_idx == MAX_ID_V) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (i_cmd.pc_upd) begin
                r_pc <= e_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.capture) begin
            r_pa <= r_prev_q;
            r_nt <= r_next_q;
        end
        if (i_cmd.res_ld) begin
            unique case (i_cmd.res_kind)
                RES_QUERY: begin
                    r_res.status   <= q_fail ? ST_NONE : ST_OK;
                    r_res.left_id  <= q_fail ? '0 : r_prev_q;
                    r_res.right_id <= q_fail ? '0 : r_next_q;
                end
                RES_NONE: begin
                    r_res.status   <= ST_NONE;
                    r_res.left_id  <= '0;
                    r_res.right_id <= '0;
                end
                default: begin
                    r_res.status   <= ST_REJECT;
                    r_res.left_id  <= '0;
                    r_res.right_id <= '0;
                end
            endcase
        end
    end

    assign o_result = r_res;

    a_access_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (re_p || i_cmd.link_en) |-> r_clr_done)
        else $error("table access before init sweep finished");

    a_pc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc != '0)
        else $error("placed count dropped to zero");

    a_pc_upd_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pc_upd |-> !o_sts.ovf)
        else $error("placed count update past table end");

endmodule

`default_nettype wire

// ----- sv/ills_ctrl.sv -----
// ----------------------------------------------------------------------------
// ills_ctrl
// Sequencer: init sweep, decode, table reads, three link steps, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ills_ctrl import ills_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy,
    output logic      o_valid
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_FIRST,
        S_RD_SECOND,
        S_LINK_FIRST,
        S_LINK_SECOND,
        S_LINK_THIRD,
        S_QUERY_EVAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.link_step = LINK_FIRST;
        o_cmd.res_kind  = RES_NONE;
        n_state         = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_sts.nop) begin
                    n_state = S_IDLE;
                end else if (i_sts.is_query && !i_sts.t_ok) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_kind = RES_NONE;
                    n_state        = S_IDLE;
                end else if (!i_sts.is_query && (!i_sts.t_ok || i_sts.ovf)) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_kind = RES_REJECT;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_RD_FIRST;
                end
            end
            S_RD_FIRST: begin
                o_cmd.rd_first = 1'b1;
                n_state = i_sts.is_query ? S_QUERY_EVAL : S_RD_SECOND;
            end
            S_RD_SECOND: begin
                o_cmd.rd_second = 1'b1;
                o_cmd.capture   = 1'b1;
                n_state         = S_LINK_FIRST;
            end
            S_LINK_FIRST: begin
                o_cmd.link_en   = 1'b1;
                o_cmd.link_step = LINK_FIRST;
                n_state         = S_LINK_SECOND;
            end
            S_LINK_SECOND: begin
                o_cmd.link_en   = 1'b1;
                o_cmd.link_step = LINK_SECOND;
                n_state         = S_LINK_THIRD;
            end
            S_LINK_THIRD: begin
                o_cmd.link_en   = 1'b1;
                o_cmd.link_step = LINK_THIRD;
                o_cmd.pc_upd    = 1'b1;
                n_state         = S_IDLE;
            end
            S_QUERY_EVAL: begin
                o_cmd.res_ld   = 1'b1;
                o_cmd.res_kind = RES_QUERY;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.res_ld;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == S_DECODE || r_state == S_QUERY_EVAL))
        else $error("result strobe from unexpected state");

    a_idle_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> i_sts.clr_done)
        else $error("idle before table init finished");

endmodule

`default_nettype wire

// ----- sv/indexed_linked_list_splicer.sv -----
// ----------------------------------------------------------------------------
// indexed_linked_list_splicer
// Doubly linked list of node ids kept in prev/next tables, with run splicing
// and neighbor queries.
// ----------------------------------------------------------------------------
// Valid query: busy in decode, first read and eval; strobe follows eval, and
//   the next item can be accepted in the strobe cycle. Reject or bad query
//   target: strobe follows decode. Empty run or unused op: busy in decode only.
// Insert: busy in decode, two reads, three link steps; no result. Reset: the
//   placed count returns to one; an init sweep writes the chained order into
//   both tables, one entry per cycle. Receiver cannot stall; strobes last one cycle.
`timescale 1ns / 1ps
`default_nettype none

module indexed_linked_list_splicer import ills_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_in  i_item,
    output logic      o_valid,
    output t_out      o_result
);

    t_cmd cmd;
    t_sts sts;

    ills_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ills_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ----- tb/sv/indexed_linked_list_splicer_tb.sv -----
// ----------------------------------------------------------------------------
// indexed_linked_list_splicer_tb
// Self-checking bench for the linked list splicer. A scoreboard keeps its own
// copy of the prev/next tables and the placed count. It predicts each query
// and each reject, and it checks every result strobe against the oldest
// prediction. Stimulus is a directed pass, then random inserts, queries, unused
// ops and empty runs with random idle gaps, then a pass that fills the table to the last id.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_linked_list_splicer_tb import ills_pkg::*;;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    class splice_scoreboard;
        bit [ID_W-1:0] prev_tbl [DEPTH];
        bit [ID_W-1:0] next_tbl [DEPTH];
        int unsigned   placed;
        t_out          pending_neighbors [$];
        int            mismatches;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                prev_tbl[i] = (i == 0) ? '0 : t_id'(i - 1);
                next_tbl[i] = (i == 0 || i == MAX_ID) ? '0 : t_id'(i + 1);
            end
            placed     = 1;
            mismatches = 0;
        endfunction

        function void link_pair(int unsigned a, int unsigned b);
            if (a != 0 && a <= MAX_ID) next_tbl[a] = t_id'(b);
            if (b != 0 && b <= MAX_ID) prev_tbl[b] = t_id'(a);
        endfunction

        function void note_item(t_in it);
            int unsigned t, len, s, e, pa, nb, l, r, nt, pt;
            bit          t_ok;
            t_out        res;
            t    = it.target_id;
            len  = it.run_length;
            t_ok = (t != 0 && t <= MAX_ID && t <= placed);
            res  = '0;
            case (it.operation)
                OP_QUERY: begin
                    res.status = ST_NONE;
                    if (t_ok) begin
                        l = prev_tbl[t];
                        r = next_tbl[t];
                        if (l != 0 && r != 0 && r <= placed) begin
                            res.status   = ST_OK;
                            res.left_id  = t_id'(l);
                            res.right_id = t_id'(r);
                        end
                    end
                    pending_neighbors.push_back(res);
                end
                OP_INS_AFTER, OP_INS_BEFORE: begin
                    if (len != 0) begin
                        if (!t_ok || placed + len > MAX_ID) begin
                            res.status = ST_REJECT;
                            pending_neighbors.push_back(res);
                        end else begin
                            s  = placed + 1;
                            e  = placed + len;
                            pa = prev_tbl[s];
                            nb = next_tbl[e];
                            if (it.operation == OP_INS_AFTER) begin
                                nt = next_tbl[t];
                                if (nt != s) begin
                                    link_pair(e, nt);
                                    link_pair(t, s);
                                    link_pair(pa, nb);
                                end
                            end else begin
                                pt = prev_tbl[t];
                                link_pair(pt, s);
                                link_pair(e, t);
                                link_pair(pa, nb);
                            end
                            placed = e;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out act);
            t_out exp;
            if (pending_neighbors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result status=%0d left=%0d right=%0d",
                             $realtime, act.status, act.left_id, act.right_id);
                return;
            end
            exp = pending_neighbors.pop_front();
            if (act.status !== exp.status || act.left_id !== exp.left_id ||
                act.right_id !== exp.right_id) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp %0d/%0d/%0d act %0d/%0d/%0d",
                             $realtime, exp.status, exp.left_id, exp.right_id,
                             act.status, act.left_id, act.right_id);
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_item  = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    splice_scoreboard sb;
    int               burst_left = 0;

    indexed_linked_list_splicer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            sb.check_result(o_result);
    end

    function automatic t_in mk(logic [1:0] op, int unsigned t, int unsigned len);
        t_in it;
        it.operation  = op;
        it.target_id  = t_id'(t);
        it.run_length = t_id'(len);
        return it;
    endfunction

    // idle gap, then hold start until the item is taken
    task automatic send_item(input t_in it);
        int roll;
        int gap;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3)       burst_left = $urandom_range(20, 60);
            else if (roll < 40) gap = 0;
            else if (roll < 85) gap = $urandom_range(1, 3);
            else if (roll < 97) gap = $urandom_range(4, 12);
            else                gap = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(it);
    endtask

    initial begin
        #2_000_000;
        $display("indexed_linked_list_splicer verification failed");
        $finish;
    end

    initial begin
        int          counted;
        int          roll;
        int          sub;
        int unsigned pc;
        int unsigned t;
        int unsigned len;
        logic [1:0]  op;

        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_item(mk(OP_QUERY, 1, 0));
        send_item(mk(OP_QUERY, 0, 5));
        send_item(mk(OP_QUERY, MAX_ID, MAX_ID));
        send_item(mk(OP_UNUSED, MAX_ID, MAX_ID));
        send_item(mk(OP_INS_AFTER, 1, 0));
        send_item(mk(OP_INS_AFTER, 1, 1));
        send_item(mk(OP_QUERY, 1, 0));
        send_item(mk(OP_QUERY, 2, 0));
        send_item(mk(OP_INS_BEFORE, 2, 3));
        send_item(mk(OP_QUERY, 2, 0));
        send_item(mk(OP_QUERY, 4, 0));
        send_item(mk(OP_INS_AFTER, 3, 2));
        send_item(mk(OP_QUERY, 6, 0));
        send_item(mk(OP_INS_BEFORE, 1, 1));
        send_item(mk(OP_QUERY, 1, 0));
        send_item(mk(OP_QUERY, 8, 0));
        send_item(mk(OP_INS_AFTER, 0, 1));
        send_item(mk(OP_INS_BEFORE, 50, 1));
        send_item(mk(OP_INS_AFTER, 1, MAX_ID));
        send_item(mk(OP_INS_AFTER, 2, MAX_ID - sb.placed + 1));
        send_item(mk(OP_QUERY, sb.placed + 1, 0));
        send_item(mk(OP_INS_AFTER, 2, 1));
        send_item(mk(OP_QUERY, 2, 0));

        // random
        counted = 0;
        while (counted < 900) begin
            roll = $urandom_range(0, 99);
            pc   = sb.placed;
            sub  = $urandom_range(0, 19);
            if (roll < 45) begin
                if (sub == 0)      t = 0;
                else if (sub == 1) t = $urandom_range(pc + 1, MAX_ID);
                else if (sub == 2) t = pc + 1;
                else               t = $urandom_range(1, pc);
                send_item(mk(OP_QUERY, t, $urandom));
            end else if (roll < 90) begin
                op = $urandom_range(0, 1) ? OP_INS_BEFORE : OP_INS_AFTER;
                if (sub == 0) begin
                    t = 0;
                end else if (sub == 1) begin
                    t = $urandom_range(pc + 1, MAX_ID);
                end else if (sub <= 3) begin
                    t  = sb.prev_tbl[pc + 1];
                    op = OP_INS_AFTER;
                end else begin
                    t = $urandom_range(1, pc);
                end
                sub = $urandom_range(0, 19);
                if (sub == 0)      len = $urandom_range(MAX_ID - pc + 1, MAX_ID);
                else if (sub == 1) len = $urandom_range(9, 64);
                else               len = $urandom_range(1, 8);
                send_item(mk(op, t, len));
            end else if (roll < 95) begin
                send_item(mk(OP_UNUSED, $urandom, $urandom));
            end else begin
                op = $urandom_range(0, 1) ? OP_INS_BEFORE : OP_INS_AFTER;
                send_item(mk(op, $urandom_range(0, MAX_ID), 0));
            end
            counted++;
        end

        // fill to the last id, then probe the full table
        send_item(mk(OP_INS_BEFORE, $urandom_range(1, sb.placed), MAX_ID - sb.placed - 1));
        send_item(mk(OP_INS_AFTER, sb.prev_tbl[sb.placed + 1], 1));
        send_item(mk(OP_QUERY, MAX_ID, 0));
        send_item(mk(OP_QUERY, MAX_ID - 1, 0));
        send_item(mk(OP_INS_AFTER, $urandom_range(1, MAX_ID), 1));
        send_item(mk(OP_QUERY, MAX_ID, 0));
        repeat (20) send_item(mk(OP_QUERY, $urandom_range(1, MAX_ID), 0));
        send_item(mk(OP_INS_BEFORE, 1, 1));
        send_item(mk(OP_QUERY, 1, 0));
        start <= 1'b0;

        while (sb.pending_neighbors.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.pending_neighbors.size() != 0) begin
            sb.mismatches++;
            $display("%0d expected results never arrived", sb.pending_neighbors.size());
        end
        if (sb.mismatches == 0) begin
            $display("indexed_linked_list_splicer verification clean");
        end else begin
            $display("indexed_linked_list_splicer verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ills_pkg.sv
sv/ills_datapath.sv
sv/ills_ctrl.sv
sv/indexed_linked_list_splicer.sv
tb/sv/indexed_linked_list_splicer_tb.sv
